[sv/lag_pkg.sv]
package lag_pkg;

    // grid size
    localparam int GRID_WIDTH  = 84;
    localparam int GRID_HEIGHT = 48;

    localparam int COL_AW  = $clog2(GRID_WIDTH);
    localparam int ROW_AW  = $clog2(GRID_HEIGHT);
    // step sequencer counts 0 .. GRID_HEIGHT + 1
    localparam int STEP_CW = $clog2(GRID_HEIGHT + 2);

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    typedef logic [GRID_WIDTH-1:0] row_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] col;
        logic [5:0] row;
        logic       cell_in;
    } req_t;

    typedef struct packed {
        logic       cell_out;
        logic [1:0] done_cmd;
    } rsp_t;

    typedef struct packed {
        logic              re;
        logic [ROW_AW-1:0] raddr;
    } ram_rd_t;

    typedef struct packed {
        logic              we;
        logic [ROW_AW-1:0] waddr;
        row_t              wdata;
    } ram_wr_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_STEP,
        ST_DONE
    } state_t;

endpackage

[sv/lag_row_ram.sv]
// One row of the grid per entry; one write and one read port, read data registered.
module lag_row_ram (
    input  logic            clk,
    input  lag_pkg::ram_rd_t rd,
    input  lag_pkg::ram_wr_t wr,
    output lag_pkg::row_t   rdata
);

    lag_pkg::row_t mem [lag_pkg::GRID_HEIGHT];
    lag_pkg::row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        if (rd.re)
        begin
            rdata_reg <= mem[rd.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/lag_row_rule.sv]
// Next state of one full row from the rows above, at and below it (B3/S23).
module lag_row_rule (
    input  lag_pkg::row_t above,
    input  lag_pkg::row_t cur,
    input  lag_pkg::row_t below,
    output lag_pkg::row_t next_row
);

    logic [lag_pkg::GRID_WIDTH+1:0] pa;
    logic [lag_pkg::GRID_WIDTH+1:0] pc;
    logic [lag_pkg::GRID_WIDTH+1:0] pb;

    // zero padding: no wraparound at the edges
    assign pa = {1'b0, above, 1'b0};
    assign pc = {1'b0, cur,   1'b0};
    assign pb = {1'b0, below, 1'b0};

    always_comb
    begin
        logic [3:0] n;
        for (int c = 0; c < lag_pkg::GRID_WIDTH; c++)
        begin
            n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
              + 4'(pc[c])                + 4'(pc[c+2])
              + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
            case (n)
                4'd2:    next_row[c] = cur[c];
                4'd3:    next_row[c] = 1'b1;
                default: next_row[c] = 1'b0;
            endcase
        end
    end

endmodule

[sv/life_automaton_generation_unit.sv]
// Game of Life (B3/S23) engine on an 84 x 48 bit grid held one row per word in a
// synchronous RAM. Requests: write cell, read cell, or advance one generation;
// every request except the unused command code gives one response echoing the
// command. Cells beyond the edge count as dead; out-of-range writes are dropped
// and out-of-range reads return 0. After reset a clearing pass (one row per
// cycle) zeroes the grid, during which no request is taken.
// A read or write goes from acceptance to response in steps (accept with RAM
// read, modify or select, response load). In a generation the sequencer
// streams rows through a three-row window, working out a whole row in 84
// parallel lanes per cycle and writing it back in place two rows behind the
// read pointer, so the single RAM read port sets the pace.
// One request is processed at a time; a finished response sits in the output
// register and the next request is accepted while it waits.
module life_automaton_generation_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  lag_pkg::req_t   req_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output lag_pkg::rsp_t   rsp_data
);

    localparam logic [lag_pkg::STEP_CW-1:0] CNT_ROW_LAST =
        lag_pkg::STEP_CW'(lag_pkg::GRID_HEIGHT - 1);
    localparam logic [lag_pkg::STEP_CW-1:0] CNT_ROWS =
        lag_pkg::STEP_CW'(lag_pkg::GRID_HEIGHT);
    localparam logic [lag_pkg::STEP_CW-1:0] CNT_END =
        lag_pkg::STEP_CW'(lag_pkg::GRID_HEIGHT + 1);
    localparam logic [lag_pkg::STEP_CW-1:0] CNT_ONE = lag_pkg::STEP_CW'(1);
    localparam logic [lag_pkg::STEP_CW-1:0] CNT_TWO = lag_pkg::STEP_CW'(2);

    // control state
    lag_pkg::state_t             state_reg, state_next;
    logic [lag_pkg::STEP_CW-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    // payload
    lag_pkg::req_t req_reg, req_next;
    lag_pkg::row_t prev_reg, prev_next;
    lag_pkg::row_t cur_reg, cur_next;
    logic          res_cell_reg, res_cell_next;
    logic [1:0]    res_cmd_reg, res_cmd_next;
    lag_pkg::rsp_t out_reg, out_next;

    lag_pkg::ram_rd_t ram_rd;
    lag_pkg::ram_wr_t ram_wr;
    lag_pkg::row_t    ram_rdata;
    lag_pkg::row_t    below_row;
    lag_pkg::row_t    new_row;
    logic             load_out;
    logic             req_inside;

    lag_row_ram u_ram (
        .clk   (clk),
        .rd    (ram_rd),
        .wr    (ram_wr),
        .rdata (ram_rdata)
    );

    // window: prev = row above, cur = row being updated, below from RAM (zero past the end)
    lag_row_rule u_rule (
        .above    (prev_reg),
        .cur      (cur_reg),
        .below    (below_row),
        .next_row (new_row)
    );

    assign below_row  = (cnt_reg <= CNT_ROWS) ? ram_rdata : '0;
    assign req_inside = (int'(req_reg.col) < lag_pkg::GRID_WIDTH)
                     && (int'(req_reg.row) < lag_pkg::GRID_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lag_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        res_cell_reg <= res_cell_next;
        res_cmd_reg  <= res_cmd_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        lag_pkg::row_t patched;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        req_next      = req_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        res_cell_next = res_cell_reg;
        res_cmd_next  = res_cmd_reg;
        ram_rd        = '0;
        ram_wr        = '0;
        req_ready     = 1'b0;
        load_out      = 1'b0;
        patched       = ram_rdata;

        unique case (state_reg)
            lag_pkg::ST_CLEAR:
            begin
                ram_wr.we    = 1'b1;
                ram_wr.waddr = lag_pkg::ROW_AW'(cnt_reg);
                ram_wr.wdata = '0;
                if (cnt_reg == CNT_ROW_LAST)
                begin
                    cnt_next   = '0;
                    state_next = lag_pkg::ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end

            lag_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next     = req_data;
                    // row fetch for read / write starts with the request
                    ram_rd.re    = 1'b1;
                    ram_rd.raddr = lag_pkg::ROW_AW'(req_data.row);
                    unique case (req_data.cmd)
                        lag_pkg::CMD_WRITE: state_next = lag_pkg::ST_WRITE;
                        lag_pkg::CMD_READ:  state_next = lag_pkg::ST_READ;
                        lag_pkg::CMD_STEP:
                        begin
                            state_next = lag_pkg::ST_STEP;
                            cnt_next   = '0;
                            prev_next  = '0;
                            cur_next   = '0;
                        end
                        default:            state_next = lag_pkg::ST_IDLE;
                    endcase
                end
            end

            lag_pkg::ST_WRITE:
            begin
                if (req_inside)
                begin
                    patched[lag_pkg::COL_AW'(req_reg.col)] = req_reg.cell_in;
                    ram_wr.we    = 1'b1;
                    ram_wr.waddr = lag_pkg::ROW_AW'(req_reg.row);
                    ram_wr.wdata = patched;
                end
                res_cell_next = 1'b0;
                res_cmd_next  = lag_pkg::CMD_WRITE;
                state_next    = lag_pkg::ST_DONE;
            end

            lag_pkg::ST_READ:
            begin
                res_cell_next = req_inside ? ram_rdata[lag_pkg::COL_AW'(req_reg.col)] : 1'b0;
                res_cmd_next  = lag_pkg::CMD_READ;
                state_next    = lag_pkg::ST_DONE;
            end

            lag_pkg::ST_STEP:
            begin
                if (cnt_reg < CNT_ROWS)
                begin
                    ram_rd.re    = 1'b1;
                    ram_rd.raddr = lag_pkg::ROW_AW'(cnt_reg);
                end
                if (cnt_reg >= CNT_ONE)
                begin
                    prev_next = cur_reg;
                    cur_next  = below_row;
                end
                // in-place write-back: old row already held in the window
                if (cnt_reg >= CNT_TWO)
                begin
                    ram_wr.we    = 1'b1;
                    ram_wr.waddr = lag_pkg::ROW_AW'(cnt_reg - CNT_TWO);
                    ram_wr.wdata = new_row;
                end
                if (cnt_reg == CNT_END)
                begin
                    res_cell_next = 1'b0;
                    res_cmd_next  = lag_pkg::CMD_STEP;
                    state_next    = lag_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end

            lag_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    load_out   = 1'b1;
                    state_next = lag_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lag_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        if (load_out)
        begin
            out_next.cell_out = res_cell_reg;
            out_next.done_cmd = res_cmd_reg;
            out_valid_next    = 1'b1;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // code 3 is left unused by the block: no response, no effect
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_REQS    = 110;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_MAX     = 10;
    localparam int DIRECTED_ROWS  = 25;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    lag_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    lag_pkg::rsp_t rsp_data;

    // side band travelling with each request: a hand-typed cell_out, if any
    logic req_typed = 1'b0;
    logic req_gold = 1'b0;

    life_automaton_generation_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Grid predictor
    // ---------------------------------------------------------------------
    bit life_grid [lag_pkg::GRID_HEIGHT][lag_pkg::GRID_WIDTH];

    function automatic bit cell_alive(input int c, input int r);
        if (c < 0 || r < 0 || c >= lag_pkg::GRID_WIDTH || r >= lag_pkg::GRID_HEIGHT)
            return 1'b0;   // beyond the edge counts as dead, no wraparound
        return life_grid[r][c];
    endfunction

    function automatic void life_generation();
        bit nxt [lag_pkg::GRID_HEIGHT][lag_pkg::GRID_WIDTH];
        int n;
        for (int r = 0; r < lag_pkg::GRID_HEIGHT; r++)
        begin
            for (int c = 0; c < lag_pkg::GRID_WIDTH; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            n += cell_alive(c + dc, r + dr);
                // B3/S23
                if (n < 2 || n > 3)
                    nxt[r][c] = 1'b0;
                else if (n == 3)
                    nxt[r][c] = 1'b1;
                else
                    nxt[r][c] = life_grid[r][c];
            end
        end
        life_grid = nxt;
    endfunction

    // applies one request to the grid; returns 1 when a response is due
    function automatic bit life_apply(input lag_pkg::req_t r, output lag_pkg::rsp_t rsp);
        bit on_grid;
        on_grid = (r.col < lag_pkg::GRID_WIDTH) && (r.row < lag_pkg::GRID_HEIGHT);
        rsp.cell_out = 1'b0;
        rsp.done_cmd = r.cmd;
        case (r.cmd)
            lag_pkg::CMD_WRITE:
            begin
                if (on_grid)
                    life_grid[r.row][r.col] = r.cell_in;
            end
            lag_pkg::CMD_READ:
            begin
                if (on_grid)
                    rsp.cell_out = life_grid[r.row][r.col];
            end
            lag_pkg::CMD_STEP:
                life_generation();
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Monitor and scoreboard
    // ---------------------------------------------------------------------
    lag_pkg::rsp_t pending_rsp [$];
    lag_pkg::rsp_t predicted;
    lag_pkg::rsp_t oldest;
    int fail_count = 0;
    int reqs_taken = 0;
    int rsps_checked = 0;
    int generations = 0;
    int reads_done = 0;
    int idle_run = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                reqs_taken++;
                if (req_data.cmd == lag_pkg::CMD_STEP)
                    generations++;
                if (req_data.cmd == lag_pkg::CMD_READ)
                    reads_done++;
                if (life_apply(req_data, predicted))
                begin
                    // typed rows override cell_out; done_cmd is always the echo
                    if (req_typed)
                        predicted.cell_out = req_gold;
                    pending_rsp.push_back(predicted);
                end
            end
            if (rsp_valid && rsp_ready)
            begin
                rsps_checked++;
                if (pending_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: response with none outstanding:", $time,
                                 " cell_out=%b done_cmd=%0d",
                                 rsp_data.cell_out, rsp_data.done_cmd);
                end
                else
                begin
                    oldest = pending_rsp.pop_front();
                    if (rsp_data.cell_out !== oldest.cell_out ||
                        rsp_data.done_cmd !== oldest.done_cmd)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: bad response: exp cell_out=%b done_cmd=%0d,",
                                     $time, oldest.cell_out, oldest.done_cmd,
                                     " got cell_out=%b done_cmd=%0d",
                                     rsp_data.cell_out, rsp_data.done_cmd);
                    end
                end
            end
        end
    end

    // watchdog: long stretch with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run == WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d responses outstanding", pending_rsp.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Response side back-pressure: the mode is redrawn at random from four modes
    // ---------------------------------------------------------------------
    int ready_mode = 0;
    int ready_tick = 0;

    always @(posedge clk)
    begin
        if (ready_tick == 49)
        begin
            ready_tick <= 0;
            ready_mode <= $urandom_range(0, 3);
        end
        else
            ready_tick <= ready_tick + 1;
        case (ready_mode)
            0: rsp_ready <= 1'b1;                               // free flowing
            1: rsp_ready <= ($urandom_range(0, 2) != 0);        // light random stalls
            2: rsp_ready <= ((ready_tick % 5) < 3);             // regular on/off stalls
            default: rsp_ready <= (ready_tick >= 30);           // one long stall
        endcase
    end

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------
    int burst_left = 0;

    // bursts of random length separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    // hold the request until taken; called and returns at a rising edge
    task automatic issue(input lag_pkg::req_t r, input logic typed, input logic gold);
        pace();
        req_valid <= 1'b1;
        req_data  <= r;
        req_typed <= typed;
        req_gold  <= gold;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic send(input logic [1:0] cmd, input int col, input int row, input logic val);
        lag_pkg::req_t r;
        r.cmd     = cmd;
        r.col     = col[6:0];
        r.row     = row[5:0];
        r.cell_in = val;
        issue(r, 1'b0, 1'b0);
    endtask

    // directed rows: typed=1 means cell_out is given by hand, else predicted
    typedef struct packed {
        logic       typed;
        logic       gold;
        logic [1:0] cmd;
        logic [6:0] col;
        logic [5:0] row;
        logic       cell_in;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b1, 1'b0, lag_pkg::CMD_READ,  7'd0,   6'd0,  1'b0},  // fresh grid, first corner
        '{1'b1, 1'b0, lag_pkg::CMD_READ,  7'd83,  6'd47, 1'b0},  // fresh grid, far corner
        '{1'b1, 1'b0, lag_pkg::CMD_WRITE, 7'd0,   6'd0,  1'b1},  // still-life block in corner
        '{1'b0, 1'b0, lag_pkg::CMD_WRITE, 7'd1,   6'd0,  1'b1},
        '{1'b0, 1'b0, lag_pkg::CMD_WRITE, 7'd0,   6'd1,  1'b1},
        '{1'b0, 1'b0, lag_pkg::CMD_WRITE, 7'd1,   6'd1,  1'b1},
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd0,   6'd0,  1'b0},
        '{1'b1, 1'b0, lag_pkg::CMD_WRITE, 7'd127, 6'd63, 1'b1},  // off-grid write, dropped
        '{1'b1, 1'b0, lag_pkg::CMD_READ,  7'd127, 6'd63, 1'b0},  // off-grid reads give 0
        '{1'b1, 1'b0, lag_pkg::CMD_READ,  7'd84,  6'd0,  1'b0},
        '{1'b1, 1'b0, lag_pkg::CMD_READ,  7'd0,   6'd48, 1'b0},
        '{1'b0, 1'b0, CMD_UNUSED,         7'd127, 6'd63, 1'b1},  // ignored, no response
        '{1'b0, 1'b0, lag_pkg::CMD_WRITE, 7'd83,  6'd45, 1'b1},  // vertical blinker, right edge
        '{1'b0, 1'b0, lag_pkg::CMD_WRITE, 7'd83,  6'd46, 1'b1},
        '{1'b0, 1'b0, lag_pkg::CMD_WRITE, 7'd83,  6'd47, 1'b1},
        '{1'b1, 1'b0, lag_pkg::CMD_STEP,  7'd0,   6'd0,  1'b0},
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd82,  6'd46, 1'b0},  // birth inside the grid
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd0,   6'd46, 1'b0},  // no wraparound birth
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd83,  6'd47, 1'b0},
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd1,   6'd1,  1'b0},
        '{1'b0, 1'b0, lag_pkg::CMD_STEP,  7'd127, 6'd63, 1'b1},
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd83,  6'd45, 1'b0},
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd82,  6'd46, 1'b0},
        '{1'b1, 1'b0, lag_pkg::CMD_WRITE, 7'd0,   6'd0,  1'b0},  // kill a block cell
        '{1'b0, 1'b0, lag_pkg::CMD_READ,  7'd0,   6'd0,  1'b0}
    };

    int random_reqs = 0;
    int episode = 0;
    int col0;
    int row0;
    int count;
    int pick;
    lag_pkg::req_t row_req;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row_req.cmd     = DIRECTED[i].cmd;
            row_req.col     = DIRECTED[i].col;
            row_req.row     = DIRECTED[i].row;
            row_req.cell_in = DIRECTED[i].cell_in;
            issue(row_req, DIRECTED[i].typed, DIRECTED[i].gold);
        end

        // random part: seed a small window, run a few generations, read back
        while (random_reqs < RANDOM_REQS)
        begin
            // window start hugs an edge half of the time in each direction
            case ($urandom_range(0, 3))
                0: col0 = 0;
                1: col0 = lag_pkg::GRID_WIDTH - 6;
                default: col0 = $urandom_range(0, lag_pkg::GRID_WIDTH - 6);
            endcase
            case ($urandom_range(0, 3))
                0: row0 = 0;
                1: row0 = lag_pkg::GRID_HEIGHT - 6;
                default: row0 = $urandom_range(0, lag_pkg::GRID_HEIGHT - 6);
            endcase

            count = $urandom_range(3, 9);
            for (int k = 0; k < count; k++)
            begin
                send(lag_pkg::CMD_WRITE, col0 + $urandom_range(0, 5),
                     row0 + $urandom_range(0, 5), $urandom_range(0, 4) != 0);
                random_reqs++;
            end

            count = $urandom_range(1, 3);
            for (int k = 0; k < count; k++)
            begin
                send(lag_pkg::CMD_STEP, $urandom_range(0, 127), $urandom_range(0, 63),
                     $urandom_range(0, 1));
                random_reqs++;
            end

            count = $urandom_range(2, 6);
            for (int k = 0; k < count; k++)
            begin
                send(lag_pkg::CMD_READ, col0 + $urandom_range(0, 5),
                     row0 + $urandom_range(0, 5), $urandom_range(0, 1));
                random_reqs++;
            end

            // noise: off-grid accesses, unused code, reads anywhere
            if ($urandom_range(0, 99) < 35)
            begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: send(lag_pkg::CMD_WRITE, $urandom_range(lag_pkg::GRID_WIDTH, 127),
                            $urandom_range(0, 63), $urandom_range(0, 1));
                    1: send(lag_pkg::CMD_READ, $urandom_range(0, 127),
                            $urandom_range(lag_pkg::GRID_HEIGHT, 63), $urandom_range(0, 1));
                    2: send(CMD_UNUSED, $urandom_range(0, 127), $urandom_range(0, 63),
                            $urandom_range(0, 1));
                    default: send(lag_pkg::CMD_READ, $urandom_range(0, 127),
                                  $urandom_range(0, 63), $urandom_range(0, 1));
                endcase
                if (pick != 2)
                    random_reqs++;
            end

            // once, hold off until the block has answered everything
            if (episode == 5)
            begin
                req_valid <= 1'b0;
                burst_left = 0;
                @(posedge clk);
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            episode++;
        end

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d generations, %0d reads), checked %0d responses,",
                 reqs_taken, generations, reads_done, rsps_checked);
        $display("over %0d seeded windows with edge, off-grid and unused-code cases; %0d errors.",
                 episode, fail_count);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
sv/lag_pkg.sv
sv/lag_row_ram.sv
sv/lag_row_rule.sv
sv/life_automaton_generation_unit.sv
verif/tb_top.sv
